// ----- hw/rtl/pqe_pkg.sv -----
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types, constants and rounding helpers of the P/Q estimator.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int unsigned RingDepthDef    = 512;
  localparam int unsigned SampleRateHzDef = 16000;

  localparam int unsigned CoefW  = 24;
  localparam int unsigned NumCoef = 8;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] IdxFreqB0  = 3'd0;
  localparam logic [CfgIdxW-1:0] IdxFreqB1  = 3'd1;
  localparam logic [CfgIdxW-1:0] IdxFreqA1  = 3'd2;
  localparam logic [CfgIdxW-1:0] IdxPowerB0 = 3'd3;
  localparam logic [CfgIdxW-1:0] IdxPowerB1 = 3'd4;
  localparam logic [CfgIdxW-1:0] IdxPowerB2 = 3'd5;
  localparam logic [CfgIdxW-1:0] IdxPowerA1 = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxPowerA2 = 3'd7;

  localparam int unsigned MacAW   = 25;
  localparam int unsigned MacBW   = 33;
  localparam int unsigned MacAccW = 64;

  localparam logic signed [MacAW-1:0] HzScale = 25'sd166886;
  localparam logic signed [23:0] FreqGate  = 24'sd35840;   // 35 Hz in 1/1024 Hz
  localparam logic signed [33:0] QLimit    = 34'sd32000;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN, ST_TAKE, ST_DIV_GO, ST_DIV_WAIT,
    ST_RING_WR, ST_RING_RA, ST_RING_RD, ST_DONE
  } pqe_state_e;

  typedef enum logic [2:0] {
    PH_X, PH_F, PH_P, PH_Q, PH_BP, PH_BQ
  } pqe_phase_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } pqe_mac_ctl_t;

  function automatic logic [2:0] phase_terms(pqe_phase_e ph);
    case (ph)
      PH_F:           phase_terms = 3'd3;
      PH_BP, PH_BQ:   phase_terms = 3'd5;
      default:        phase_terms = 3'd1;
    endcase
  endfunction

  // (acc + 2^21) >> 22, floor shift
  function automatic logic signed [MacAccW-1:0] rnd22(logic signed [MacAccW-1:0] acc);
    rnd22 = (acc + 64'sd2097152) >>> 22;
  endfunction

endpackage

// ----- hw/rtl/pqe_ram.sv -----
// ----------------------------------------------------------------------------
// pqe_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module pqe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pqe_div.sv -----
// ----------------------------------------------------------------------------
// pqe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pqe_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VW:0]   trial;

  assign trial = {rem_q[VW-1:0], quo_q[DW-1]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hw/rtl/pqe_mac.sv -----
// ----------------------------------------------------------------------------
// pqe_mac
// Shared multiply-accumulate: registered product, then add or subtract.
// ----------------------------------------------------------------------------
module pqe_mac import pqe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pqe_mac_ctl_t               ctl_i,
  input  logic signed [MacAW-1:0]    a_i,
  input  logic signed [MacBW-1:0]    b_i,
  output logic signed [MacAccW-1:0]  acc_o
);

  localparam int unsigned PW = MacAW + MacBW;

  pqe_mac_ctl_t               ctl_q;
  logic signed [PW-1:0]       prod_q;
  logic signed [MacAccW-1:0]  acc_q, acc_d, prod_ext;

  assign prod_ext = MacAccW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_q.en) begin
      acc_d = (ctl_q.clr ? '0 : acc_q) + (ctl_q.sub ? -prod_ext : prod_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ----- hw/rtl/single_phase_pq_estimator_top.sv -----
// ----------------------------------------------------------------------------
// single_phase_pq_estimator_top
// Single-phase P/Q estimator with quarter-period voltage delay.
// ----------------------------------------------------------------------------
// One input beat per grid sample gives one output beat. Every product runs
// through one shared multiply-accumulate under a sequencer, and the period
// length comes from a serial divider; the next input beat is taken only once
// the last sample's output beat is loaded. With the frequency at or below
// 35 Hz the divide, ring access and instantaneous products are skipped. A
// stalled output beat holds the block in its last state until it is taken.
// After reset the voltage ring is cleared, one entry a cycle, before the first
// input beat is taken; configuration writes are taken at any time.
module single_phase_pq_estimator_top import pqe_pkg::*; #(
  parameter int unsigned RING_DEPTH     = RingDepthDef,
  parameter int unsigned SAMPLE_RATE_HZ = SampleRateHzDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoefW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // angular_freq[15:0], volt_sample[31:16], curr_sample[47:32]
  input  logic [47:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // real_power[23:0], reactive_power[39:24], power_change[63:40]
  output logic [63:0]         m_axis_tdata
);

  localparam int unsigned RI = $clog2(RING_DEPTH);
  localparam int unsigned DIVIDEND = SAMPLE_RATE_HZ * 1024;
  localparam int unsigned DW = $clog2(DIVIDEND + 1);
  localparam logic [DW-1:0] TMAX = DW'(RING_DEPTH - 1);
  localparam logic [RI-1:0] CLR_LAST = RI'(RING_DEPTH - 1);

  pqe_state_e state_q, state_d;
  pqe_phase_e ph_q, ph_d;
  logic [2:0] k_q, k_d;

  logic signed [CoefW-1:0] coef_q [NumCoef];

  logic [15:0]        w_q;
  logic signed [15:0] v_q, c_q, v90_q;
  logic [23:0]        x_q, xp_q;
  logic signed [23:0] yp_q;
  logic [RI:0]        wi_q;
  logic [RI-1:0]      t_q, ridx_q, clr_q;
  logic signed [31:0] hp_q, hq_q, pin0_q, pin1_q, pout0_q, pout1_q;
  logic signed [31:0] qin0_q, qin1_q, qout0_q, qout1_q;
  logic signed [23:0] rp_q, rdp_q;
  logic signed [15:0] rq_q;
  logic               out_vld_q;
  logic [63:0]        out_data_q;

  pqe_mac_ctl_t               mac_ctl;
  logic signed [MacAW-1:0]    mac_a;
  logic signed [MacBW-1:0]    mac_b;
  logic signed [MacAccW-1:0]  acc;
  logic signed [MacAccW-1:0]  r22;

  logic          div_start, div_done;
  logic [DW-1:0] quot;

  logic          ram_we;
  logic [RI-1:0] ram_waddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic          accept, out_load;
  logic [RI:0]   wi_eff;
  logic [RI+1:0] t_ext, q4, t34, idx;

  // ---- shared units
  pqe_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(mac_ctl), .a_i(mac_a), .b_i(mac_b), .acc_o(acc)
  );

  pqe_div #(.DW(DW), .VW(24)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(DW'(DIVIDEND)),
    .divisor_i(yp_q), .done_o(div_done), .quot_o(quot)
  );

  pqe_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ridx_q), .rdata_o(ram_rdata)
  );

  assign accept = s_axis_tvalid & s_axis_tready;
  assign r22    = rnd22(acc);

  // ring indexes: the two counters of the scheme always move together, so wi_q serves both
  assign wi_eff = (wi_q > {1'b0, t_q}) ? '0 : wi_q;
  assign t_ext  = {2'b00, t_q};
  assign q4     = t_ext >> 2;
  assign t34    = (t_ext + (t_ext << 1)) >> 2;
  assign idx    = ({1'b0, wi_eff} < q4) ? t34 + {1'b0, wi_eff} : {1'b0, wi_eff} - q4;

  // ---- operand select
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    case (ph_q)
      PH_X: begin
        mac_a = HzScale;
        mac_b = MacBW'({1'b0, w_q});
      end
      PH_F: begin
        case (k_q)
          3'd0:    begin mac_a = MacAW'(coef_q[IdxFreqB0]); mac_b = MacBW'({1'b0, x_q}); end
          3'd1:    begin mac_a = MacAW'(coef_q[IdxFreqB1]); mac_b = MacBW'({1'b0, xp_q}); end
          default: begin mac_a = MacAW'(coef_q[IdxFreqA1]); mac_b = MacBW'(yp_q); end
        endcase
      end
      PH_P: begin mac_a = MacAW'(c_q); mac_b = MacBW'(v_q); end
      PH_Q: begin mac_a = MacAW'(c_q); mac_b = MacBW'(v90_q); end
      PH_BP, PH_BQ: begin
        case (k_q)
          3'd0: begin
            mac_a = MacAW'(coef_q[IdxPowerB0]);
            mac_b = MacBW'((ph_q == PH_BP) ? hp_q : hq_q);
          end
          3'd1: begin
            mac_a = MacAW'(coef_q[IdxPowerB1]);
            mac_b = MacBW'((ph_q == PH_BP) ? pin0_q : qin0_q);
          end
          3'd2: begin
            mac_a = MacAW'(coef_q[IdxPowerB2]);
            mac_b = MacBW'((ph_q == PH_BP) ? pin1_q : qin1_q);
          end
          3'd3: begin
            mac_a = MacAW'(coef_q[IdxPowerA1]);
            mac_b = MacBW'((ph_q == PH_BP) ? pout0_q : qout0_q);
          end
          default: begin
            mac_a = MacAW'(coef_q[IdxPowerA2]);
            mac_b = MacBW'((ph_q == PH_BP) ? pout1_q : qout1_q);
          end
        endcase
      end
      default: ;
    endcase
  end

  // ---- saturation of the filter results
  logic signed [23:0] y_sat;
  logic signed [31:0] b_sat;
  always_comb begin
    if (r22 > 64'sd8388607)       y_sat = 24'sh7fffff;
    else if (r22 < -64'sd8388608) y_sat = -24'sd8388608;
    else                          y_sat = r22[23:0];
    if (r22 > 64'sd2147483647)       b_sat = 32'sh7fffffff;
    else if (r22 < -64'sd2147483648) b_sat = -32'sd2147483648;
    else                             b_sat = r22[31:0];
  end

  logic signed [33:0] pw_w, dp_w, qw_w;
  logic signed [23:0] pw_s, dp_s;
  logic signed [15:0] qw_s;
  always_comb begin
    pw_w = (34'(b_sat) + 34'sd256) >>> 9;
    dp_w = (34'(b_sat) - 34'(pout0_q) + 34'sd256) >>> 9;
    qw_w = (34'(b_sat) + 34'sd256) >>> 9;
    if (pw_w > 34'sd8388607)       pw_s = 24'sh7fffff;
    else if (pw_w < -34'sd8388608) pw_s = -24'sd8388608;
    else                           pw_s = pw_w[23:0];
    if (dp_w > 34'sd8388607)       dp_s = 24'sh7fffff;
    else if (dp_w < -34'sd8388608) dp_s = -24'sd8388608;
    else                           dp_s = dp_w[23:0];
    if (qw_w >= QLimit)       qw_s = QLimit[15:0];
    else if (qw_w <= -QLimit) qw_s = 16'(-QLimit);
    else                      qw_s = qw_w[15:0];
  end

  // ---- sequencer
  always_comb begin
    state_d       = state_q;
    ph_d          = ph_q;
    k_d           = k_q;
    mac_ctl       = '0;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_q;
    ram_wdata     = '0;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_MAC;
          ph_d    = PH_X;
          k_d     = '0;
        end
      end
      ST_MAC: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (k_q == 3'd0);
        mac_ctl.sub = ((ph_q == PH_F) && (k_q == 3'd2)) || (k_q == 3'd3) || (k_q == 3'd4);
        k_d = k_q + 1'b1;
        if (k_q == phase_terms(ph_q) - 1'b1) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_TAKE;
      ST_TAKE: begin
        k_d     = '0;
        state_d = ST_MAC;
        case (ph_q)
          PH_X:  ph_d = PH_F;
          PH_F: begin
            if (y_sat > FreqGate) state_d = ST_DIV_GO;
            else                  ph_d = PH_BP;
          end
          PH_P:  ph_d = PH_Q;
          PH_Q:  ph_d = PH_BP;
          PH_BP: ph_d = PH_BQ;
          default: state_d = ST_DONE;
        endcase
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_done) state_d = ST_RING_WR;
      ST_RING_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wi_eff[RI-1:0];
        ram_wdata = v_q;
        state_d   = ST_RING_RA;
      end
      ST_RING_RA: state_d = ST_RING_RD;
      ST_RING_RD: begin
        state_d = ST_MAC;
        ph_d    = PH_P;
        k_d     = '0;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ph_q    <= PH_X;
      k_q     <= '0;
      clr_q   <= '0;
      for (int i = 0; i < NumCoef; i++) coef_q[i] <= '0;
      xp_q    <= '0;
      yp_q    <= '0;
      wi_q    <= '0;
      hp_q    <= '0;
      hq_q    <= '0;
      pin0_q  <= '0;
      pin1_q  <= '0;
      pout0_q <= '0;
      pout1_q <= '0;
      qin0_q  <= '0;
      qin1_q  <= '0;
      qout0_q <= '0;
      qout1_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      k_q     <= k_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) coef_q[cfg_idx_i] <= cfg_data_i;
      if (state_q == ST_TAKE) begin
        case (ph_q)
          PH_F: begin
            xp_q <= x_q;
            yp_q <= y_sat;
          end
          PH_P: hp_q <= acc[31:0];
          PH_Q: hq_q <= acc[31:0];
          PH_BP: begin
            pin1_q  <= pin0_q;
            pin0_q  <= hp_q;
            pout1_q <= pout0_q;
            pout0_q <= b_sat;
          end
          PH_BQ: begin
            qin1_q  <= qin0_q;
            qin0_q  <= hq_q;
            qout1_q <= qout0_q;
            qout0_q <= b_sat;
          end
          default: ;
        endcase
      end
      if (state_q == ST_RING_WR) wi_q <= wi_eff + 1'b1;
      if (out_load)           out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q <= s_axis_tdata[15:0];
      v_q <= s_axis_tdata[31:16];
      c_q <= s_axis_tdata[47:32];
    end
    if (state_q == ST_TAKE && ph_q == PH_X) begin
      x_q <= 24'((acc + 64'sd32768) >>> 16);
    end
    if (state_q == ST_TAKE && ph_q == PH_BP) begin
      rp_q  <= pw_s;
      rdp_q <= dp_s;
    end
    if (state_q == ST_TAKE && ph_q == PH_BQ) begin
      rq_q <= qw_s;
    end
    if (div_done) begin
      t_q <= (quot > TMAX) ? TMAX[RI-1:0] : quot[RI-1:0];
    end
    if (state_q == ST_RING_WR) ridx_q <= idx[RI-1:0];
    if (state_q == ST_RING_RD) v90_q <= ram_rdata;
    if (out_load) begin
      out_data_q <= {rdp_q, rq_q, rp_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---- checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MAC && ph_q == PH_X && k_q == 3'd0))
    else $error("sample accept did not start frequency scaling");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_wi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q <= (RI+1)'(RING_DEPTH))
    else $error("ring write index out of range");

  a_ridx_in_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RING_RA |-> ridx_q <= t_q)
    else $error("quarter read index beyond period");

  a_no_load_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready))
    else $error("output register overwritten");

endmodule

// ----- bench/pq_power_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq_power_checker
// Watches the config port and both streams, predicts P/Q/dP per sample beat
// and compares every output beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module pq_power_checker import pqe_pkg::*; #(
  parameter int unsigned RING_DEPTH     = RingDepthDef,
  parameter int unsigned SAMPLE_RATE_HZ = SampleRateHzDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [63:0]        m_axis_tdata,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [23:0] dpow;
    logic signed [15:0] qpow;
    logic signed [23:0] ppow;
  } power_beat_t;

  longint coef [NumCoef];
  longint freq_x_prev, freq_y_prev;
  shortint volt_ring [RING_DEPTH];
  int unsigned wr_idx, qt_idx;
  longint p_hold, q_hold;
  longint p_xh [2], p_yh [2], q_xh [2], q_yh [2];
  power_beat_t power_queue [$];

  assign pending_count = power_queue.size();

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint run_biquad(longint x0, ref longint xh [2], ref longint yh [2]);
    longint acc, y;
    acc = coef[IdxPowerB0] * x0 + coef[IdxPowerB1] * xh[0] + coef[IdxPowerB2] * xh[1]
        - coef[IdxPowerA1] * yh[0] - coef[IdxPowerA2] * yh[1];
    y = clip(rshift(acc, 22), 32);
    xh[1] = xh[0]; xh[0] = x0;
    yh[1] = yh[0]; yh[0] = y;
    return y;
  endfunction

  function automatic power_beat_t predict_power(logic [47:0] d);
    longint w, v, c, x, y, yp, yq, qw, v90;
    int unsigned t, q4, idx;
    power_beat_t r;
    w = longint'(d[15:0]);
    v = longint'($signed(d[31:16]));
    c = longint'($signed(d[47:32]));
    x = (w * 166886 + 32768) >>> 16;
    y = clip(rshift(coef[IdxFreqB0] * x + coef[IdxFreqB1] * freq_x_prev
                    - coef[IdxFreqA1] * freq_y_prev, 22), 24);
    freq_x_prev = x;
    freq_y_prev = y;
    if (y > 35 * 1024) begin
      t = int'((longint'(SAMPLE_RATE_HZ) * 1024) / y);
      if (t > RING_DEPTH - 1) t = RING_DEPTH - 1;
      if (wr_idx > t) begin
        wr_idx = 0;
        qt_idx = 0;
      end
      volt_ring[wr_idx] = shortint'(v);
      q4 = t / 4;
      idx = (qt_idx < q4) ? (3 * t) / 4 + qt_idx : qt_idx - q4;
      v90 = (idx < RING_DEPTH) ? longint'(volt_ring[idx]) : 0;
      wr_idx++;
      qt_idx++;
      p_hold = c * v;
      q_hold = c * v90;
    end
    yp = run_biquad(p_hold, p_xh, p_yh);
    yq = run_biquad(q_hold, q_xh, q_yh);
    qw = rshift(yq, 9);
    if (qw >= 32000) qw = 32000;
    else if (qw <= -32000) qw = -32000;
    r.ppow = 24'(clip(rshift(yp, 9), 24));
    r.qpow = 16'(qw);
    r.dpow = 24'(clip(rshift(yp - p_yh[1], 9), 24));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    power_beat_t got, want;
    if (!rst_ni) begin
      foreach (coef[i]) coef[i] = 0;
      foreach (volt_ring[i]) volt_ring[i] = 0;
      freq_x_prev = 0; freq_y_prev = 0;
      wr_idx = 0; qt_idx = 0;
      p_hold = 0; q_hold = 0;
      p_xh = '{0, 0}; p_yh = '{0, 0}; q_xh = '{0, 0}; q_yh = '{0, 0};
      power_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we_i) coef[cfg_idx_i] = longint'($signed(cfg_data_i));
      if (s_axis_tvalid && s_axis_tready) power_queue.push_back(predict_power(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (power_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected output beat %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = power_queue.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch P exp %0d got %0d, Q exp %0d got %0d, dP exp %0d got %0d",
                       want.ppow, got.ppow, want.qpow, got.qpow, want.dpow, got.dpow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/single_phase_pq_estimator_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_phase_pq_estimator_top_test
// Stimulus for the P/Q estimator: coefficient phases, directed and random
// sample beats with random gaps and output stalls; verdict from the checker.
// ----------------------------------------------------------------------------
module single_phase_pq_estimator_top_test;
  import pqe_pkg::*;

  localparam int unsigned Q22One = 1 << 22;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = IdxFreqB0;
  logic [CoefW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;
  int                 fail_count, pending_count;
  int                 cycle_count = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_off = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  single_phase_pq_estimator_top dut (.*);

  pq_power_checker checker_i (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // output stall: random bursts, plus one long hold-off
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_coef(logic [CfgIdxW-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[23:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_filters(int fb0, int fb1, int fa1, int b0, int b1, int b2, int a1, int a2);
    write_coef(IdxFreqB0, fb0);
    write_coef(IdxFreqB1, fb1);
    write_coef(IdxFreqA1, fa1);
    write_coef(IdxPowerB0, b0);
    write_coef(IdxPowerB1, b1);
    write_coef(IdxPowerB2, b2);
    write_coef(IdxPowerA1, a1);
    write_coef(IdxPowerA2, a2);
  endtask

  // the beat stays up after its accept; the next call or the drain drops it
  task automatic send_sample(logic [15:0] w, logic [15:0] v, logic [15:0] c);
    int n;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, v, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // 50 Hz is about 20106 in 1/64 rad/s
  task automatic random_samples(int count);
    logic [15:0] w;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0:       w = 16'($urandom());
        1:       w = 16'($urandom_range(0, 14000));
        default: w = 16'($urandom_range(18000, 22500));
      endcase
      send_sample(w, 16'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // pass-through frequency filter, mild power low-pass
    load_filters(Q22One, 0, 0, Q22One / 4, Q22One / 4, Q22One / 4, -(Q22One / 4), 0);
    send_sample(16'h0000, 16'h7fff, 16'h7fff);
    send_sample(16'hffff, 16'h8000, 16'h8000);
    send_sample(16'd14000, 16'h8000, 16'h7fff);
    send_sample(16'd15000, 16'h1234, 16'hedcb);
    for (int k = 0; k < 12; k++)
      send_sample(16'd20106, k[0] ? 16'h8000 : 16'h7fff, 16'h8000);
    send_sample(16'd100, 16'h4000, 16'h4000);
    send_sample(16'd64000, 16'h4000, 16'hc000);
    send_sample(16'd40000, 16'hffff, 16'h0001);
    wait_drained();

    // extremes: large gains saturate every stage
    load_filters(24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff,
                 24'h7fffff, 24'h800000, 24'h800000);
    random_samples(150);
    wait_drained();

    load_filters(24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
                 24'h800000, 24'h7fffff, 24'h7fffff);
    random_samples(100);
    wait_drained();

    // smoothing frequency filter, stable biquad; long stall midway
    load_filters(Q22One / 8, Q22One / 8, -(Q22One * 3 / 4), Q22One / 16, Q22One / 8,
                 Q22One / 16, -(Q22One * 3 / 2), Q22One * 9 / 16);
    random_samples(200);
    hold_off = 1'b1;
    random_samples(250);
    wait_drained();

    load_filters(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                 int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
    random_samples(150);
    wait_drained();

    load_filters(Q22One, 0, 0, Q22One, 0, 0, 0, 0);
    random_samples(200);
    no_idle = 1'b1;
    random_samples(200);
    wait_drained();

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
